[src/sect_pkg.sv]
package sect_pkg;

  localparam int unsigned FullDepth  = 64;
  localparam int unsigned NthDepth   = 64;
  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned CountWidth = 32;

  localparam int unsigned SigKeyW = 32;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned CntOutW = 32;
  localparam int unsigned RateW   = 16;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [RateW-1:0] RateRst = RateW'(1);

  typedef enum logic {
    REG_RATE = 1'b0,
    REG_NONE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [SigKeyW-1:0] sig_key;
    logic               entry;
  } item_t;

  typedef struct packed {
    logic [SlotW-1:0]   slot;
    logic               hit;
    logic               evict;
    logic [CntOutW-1:0] entries;
    logic [CntOutW-1:0] exits;
  } tab_res_t;

  typedef struct packed {
    logic [SlotW-1:0]   full_slot;
    logic               full_hit;
    logic               full_evict;
    logic [CntOutW-1:0] full_entries;
    logic [CntOutW-1:0] full_exits;
    logic               sampled;
    logic [SlotW-1:0]   nth_slot;
    logic               nth_hit;
    logic               nth_evict;
    logic [CntOutW-1:0] nth_entries;
    logic [CntOutW-1:0] nth_exits;
  } result_t;

  typedef struct packed {
    logic cmp;
    logic upd;
    logic hit;
  } cell_ctl_t;

endpackage

[src/sect_cell.sv]
module sect_cell #(
  parameter int unsigned KEY_W   = sect_pkg::KeyWidth,
  parameter int unsigned CNT_W   = sect_pkg::CountWidth,
  parameter bit          TOK_RST = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sect_pkg::cell_ctl_t ctl_i,
  input  logic [KEY_W-1:0]    cmp_key_i,
  input  logic [KEY_W-1:0]    wr_key_i,
  input  logic [CNT_W-1:0]    ent_i,
  input  logic [CNT_W-1:0]    ext_i,
  input  logic                tok_i,
  output logic                match_o,
  output logic                sel_o,
  output logic                tok_o,
  output logic [CNT_W-1:0]    ent_o,
  output logic [CNT_W-1:0]    ext_o
);

  logic [KEY_W-1:0] key_q;
  logic             valid_q;
  logic             match_q;
  logic             tok_q;
  logic [CNT_W-1:0] ent_q;
  logic [CNT_W-1:0] ext_q;
  logic             sel;
  logic             wr;

  // on a hit the matching cell is written, on a miss the token holder
  assign sel = ctl_i.hit ? match_q : tok_q;
  assign wr  = ctl_i.upd & sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
      tok_q   <= TOK_RST;
      ent_q   <= '0;
      ext_q   <= '0;
    end else begin
      if (ctl_i.cmp) begin
        match_q <= valid_q && (key_q == cmp_key_i);
      end
      if (ctl_i.upd && !ctl_i.hit) begin
        tok_q <= tok_i;
      end
      if (wr) begin
        valid_q <= 1'b1;
        ent_q   <= ent_i;
        ext_q   <= ext_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      key_q <= wr_key_i;
    end
  end

  assign match_o = match_q;
  assign sel_o   = sel;
  assign tok_o   = tok_q;
  assign ent_o   = ent_q;
  assign ext_o   = ext_q;

endmodule

[src/sect_table.sv]
module sect_table #(
  parameter int unsigned DEPTH = sect_pkg::FullDepth,
  parameter int unsigned KEY_W = sect_pkg::KeyWidth,
  parameter int unsigned CNT_W = sect_pkg::CountWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmp_i,
  input  logic               upd_i,
  input  logic               apply_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic               entry_i,
  output sect_pkg::tab_res_t res_o
);

  logic [KEY_W-1:0]           key_q;
  logic                       entry_q;
  logic                       full_q;
  sect_pkg::tab_res_t         res_q;
  logic [DEPTH-1:0]           match;
  logic [DEPTH-1:0]           sel;
  logic [DEPTH-1:0]           tok;
  logic [CNT_W-1:0]           ent [DEPTH];
  logic [CNT_W-1:0]           ext [DEPTH];
  logic                       hit;
  logic                       upd;
  sect_pkg::cell_ctl_t        ctl;
  logic [CNT_W-1:0]           sel_ent;
  logic [CNT_W-1:0]           sel_ext;
  logic [CNT_W-1:0]           new_ent;
  logic [CNT_W-1:0]           new_ext;
  logic [sect_pkg::SlotW-1:0] slot;

  assign hit = |match;
  assign upd = upd_i & apply_i;
  assign ctl = '{cmp: cmp_i, upd: upd, hit: hit};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sect_cell #(
      .KEY_W  (KEY_W),
      .CNT_W  (CNT_W),
      .TOK_RST(i == 0)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .cmp_key_i(key_i),
      .wr_key_i (key_q),
      .ent_i    (new_ent),
      .ext_i    (new_ext),
      .tok_i    (tok[(i + DEPTH - 1) % DEPTH]),
      .match_o  (match[i]),
      .sel_o    (sel[i]),
      .tok_o    (tok[i]),
      .ent_o    (ent[i]),
      .ext_o    (ext[i])
    );
  end

  always_comb begin
    sel_ent = '0;
    sel_ext = '0;
    slot    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel[i]) begin
        sel_ent = sel_ent | ent[i];
        sel_ext = sel_ext | ext[i];
        slot    = slot | sect_pkg::SlotW'(i);
      end
    end
  end

  // saturating bump on a hit, fresh counts on a miss
  always_comb begin
    if (hit) begin
      new_ent = (entry_q && !(&sel_ent)) ? sel_ent + CNT_W'(1) : sel_ent;
      new_ext = (!entry_q && !(&sel_ext)) ? sel_ext + CNT_W'(1) : sel_ext;
    end else begin
      new_ent = CNT_W'(entry_q);
      new_ext = CNT_W'(!entry_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (upd && !hit && tok[DEPTH-1]) begin
      full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_i) begin
      key_q   <= key_i;
      entry_q <= entry_i;
    end
    if (upd_i) begin
      if (apply_i) begin
        res_q.slot    <= slot;
        res_q.hit     <= hit;
        res_q.evict   <= !hit && full_q;
        res_q.entries <= sect_pkg::CntOutW'(new_ent);
        res_q.exits   <= sect_pkg::CntOutW'(new_ext);
      end else begin
        res_q <= '0;
      end
    end
  end

  assign res_o = res_q;

endmodule

[src/sampled_event_count_table_top.sv]
// Counts method entry and exit events per signature key in two tables of
// counter cells with FIFO replacement; every n-th event, n being the rate
// register, also goes to the second table. An item is taken when start is
// high and busy is low; busy then stays high for one cycle while the cells
// compare and update, and the result shows on res_o with res_valid_o high in
// the following cycle; a new item may start in the cycle the result is shown.
// The receiver cannot stall: each result is valid for that single cycle
// only. Counters and valid bits clear at reset, so there is no clearing
// pass. Writing the rate register restarts the sampling phase; write it only
// while idle.
module sampled_event_count_table_top #(
  parameter int unsigned FULL_DEPTH  = sect_pkg::FullDepth,
  parameter int unsigned NTH_DEPTH   = sect_pkg::NthDepth,
  parameter int unsigned KEY_WIDTH   = sect_pkg::KeyWidth,
  parameter int unsigned COUNT_WIDTH = sect_pkg::CountWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  sect_pkg::item_t              item_i,
  output logic                         res_valid_o,
  output sect_pkg::result_t            res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sect_pkg::AddrW-1:0]   paddr,
  input  logic [sect_pkg::DataW-1:0]   pwdata,
  output logic [sect_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  logic                            busy_q;
  logic                            done_q;
  logic                            sampled_q;
  logic [sect_pkg::RateW-1:0]      rate_q;
  logic [sect_pkg::RateW-1:0]      phase_q;
  logic                            accept;
  logic                            cfg_wr;
  sect_pkg::reg_idx_e              reg_idx;
  logic [sect_pkg::RateW-1:0]      rate_eff;
  logic [sect_pkg::RateW:0]        phase_nxt;
  logic                            hit_rate;
  logic [KEY_WIDTH-1:0]            key;
  sect_pkg::tab_res_t              full_res;
  sect_pkg::tab_res_t              nth_res;

  assign accept   = start && !busy_q;
  assign reg_idx  = sect_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign prdata   = (reg_idx == sect_pkg::REG_RATE) ?
                    sect_pkg::DataW'(rate_q) : '0;

  assign rate_eff  = (rate_q == '0) ? sect_pkg::RateW'(1) : rate_q;
  assign phase_nxt = {1'b0, phase_q} + (sect_pkg::RateW + 1)'(1);
  assign hit_rate  = phase_nxt >= {1'b0, rate_eff};
  assign key       = KEY_WIDTH'(item_i.sig_key);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      sampled_q <= 1'b0;
      rate_q    <= sect_pkg::RateRst;
      phase_q   <= '0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      if (cfg_wr && reg_idx == sect_pkg::REG_RATE) begin
        rate_q  <= pwdata[sect_pkg::RateW-1:0];
        phase_q <= '0;
      end else if (accept) begin
        phase_q <= hit_rate ? '0 : phase_nxt[sect_pkg::RateW-1:0];
      end
      if (accept) begin
        sampled_q <= hit_rate;
      end
    end
  end

  sect_table #(
    .DEPTH(FULL_DEPTH),
    .KEY_W(KEY_WIDTH),
    .CNT_W(COUNT_WIDTH)
  ) u_full (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmp_i  (accept),
    .upd_i  (busy_q),
    .apply_i(1'b1),
    .key_i  (key),
    .entry_i(item_i.entry),
    .res_o  (full_res)
  );

  sect_table #(
    .DEPTH(NTH_DEPTH),
    .KEY_W(KEY_WIDTH),
    .CNT_W(COUNT_WIDTH)
  ) u_nth (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmp_i  (accept),
    .upd_i  (busy_q),
    .apply_i(sampled_q),
    .key_i  (key),
    .entry_i(item_i.entry),
    .res_o  (nth_res)
  );

  assign busy        = busy_q;
  assign res_valid_o = done_q;

  always_comb begin
    res_o.full_slot    = full_res.slot;
    res_o.full_hit     = full_res.hit;
    res_o.full_evict   = full_res.evict;
    res_o.full_entries = full_res.entries;
    res_o.full_exits   = full_res.exits;
    res_o.sampled      = sampled_q;
    res_o.nth_slot     = nth_res.slot;
    res_o.nth_hit      = nth_res.hit;
    res_o.nth_evict    = nth_res.evict;
    res_o.nth_entries  = nth_res.entries;
    res_o.nth_exits    = nth_res.exits;
  end

endmodule

[src/sect_checker.sv]
module sect_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              res_valid_o,
  input sect_pkg::result_t res_o
);

  // an accepted item keeps the block busy for one cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> res_valid_o && !busy)
    else $error("busy cycle not followed by a result");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result without a preceding busy cycle");

  a_unsampled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.sampled |->
      res_o.nth_slot == '0 && !res_o.nth_hit && !res_o.nth_evict &&
      res_o.nth_entries == '0 && res_o.nth_exits == '0)
    else $error("unsampled item carries second table fields");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.full_hit && res_o.full_evict) &&
      !(res_o.nth_hit && res_o.nth_evict))
    else $error("hit and eviction reported together");

endmodule

bind sampled_event_count_table_top sect_checker u_sect_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);
